>>> sv/rcs_pkg.sv
// Shared types and constants of the random cell sampler.
package rcs_pkg;

    localparam int RND_W        = 31;  // random word width
    localparam int SIDE_CFG_W   = 9;   // matrix_side register width
    localparam int COUNT_CFG_W  = 17;  // sample_count register width
    localparam int CFG_DATA_W   = 17;  // widest register
    localparam int CFG_IDX_W    = 4;
    localparam int ROWCOL_W     = 8;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [SIDE_CFG_W-1:0]  SIDE_RESET  = 9'd100;
    localparam logic [COUNT_CFG_W-1:0] COUNT_RESET = 17'd2000;

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIDE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 4'd1;

    localparam logic ACT_DRAW    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [3:0] {
        S_PREP,
        S_CLEAR,
        S_IDLE,
        S_MOD_START,
        S_MOD,
        S_READ,
        S_SWAP_POS,
        S_SWAP_J,
        S_DIV,
        S_EMIT
    } t_state;

    typedef enum logic {
        DIV_MOD,
        DIV_SIDE
    } t_div_mode;

    typedef struct packed {
        logic      clear_start;
        logic      clear_we;
        logic      latch_in;
        logic      div_start;
        t_div_mode div_mode;
        logic      rd_en;
        logic      wr_pos;
        logic      wr_j;
        logic      load_result;
        logic      load_exh;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic exhausted;
        logic div_done;
        logic out_free;
        logic cfg_restart;
    } t_status;

endpackage

>>> sv/rcs_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module rcs_divider
    import rcs_pkg::*;
#(
    parameter int DIVIDEND_W = 31,
    parameter int DIVISOR_W  = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DIVIDEND_W-1:0]         i_dividend,
    input  logic [DIVISOR_W-1:0]          i_divisor,
    input  logic [$clog2(DIVIDEND_W+1)-1:0] i_steps,
    output logic                          o_done,
    output logic [DIVIDEND_W-1:0]         o_quotient,
    output logic [DIVISOR_W-1:0]          o_remainder
);

    localparam int STEP_W = $clog2(DIVIDEND_W+1);

    logic [DIVIDEND_W-1:0] r_q;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_d;
    logic [STEP_W-1:0]     r_cnt;
    logic                  r_done;

    logic [DIVISOR_W:0]    w_shifted;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_fits;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        w_shifted = {r_rem, r_q[DIVIDEND_W-1]};
        w_fits    = (w_shifted >= {1'b0, r_d});
        w_diff    = w_shifted - {1'b0, r_d};
        n_rem     = w_fits ? w_diff[DIVISOR_W-1:0] : w_shifted[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= i_steps;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[DIVIDEND_W-2:0], w_fits};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

>>> sv/rcs_controller.sv
// Sequencer of the sampler: clearing pass, draw steps and result hand-off.
module rcs_controller
    import rcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_tuser,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_ready;
    logic   w_accept;

    assign w_ready    = (r_state == S_IDLE) && !i_status.cfg_restart;
    assign w_accept   = w_ready && i_s_tvalid;
    assign o_s_tready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PREP;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        if (i_status.cfg_restart) begin
            n_state = S_PREP;
        end else begin
            unique case (r_state)
                S_PREP:      n_state = S_CLEAR;
                S_CLEAR: begin
                    if (i_status.clear_done) n_state = S_IDLE;
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_s_tuser == ACT_RESTART) begin
                            n_state = S_PREP;
                        end else if (i_status.exhausted) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_MOD_START;
                        end
                    end
                end
                S_MOD_START: n_state = S_MOD;
                S_MOD: begin
                    if (i_status.div_done) n_state = S_READ;
                end
                S_READ:      n_state = S_SWAP_POS;
                S_SWAP_POS:  n_state = S_SWAP_J;
                S_SWAP_J:    n_state = S_DIV;
                S_DIV: begin
                    if (i_status.div_done) n_state = S_EMIT;
                end
                S_EMIT: begin
                    if (i_status.out_free) n_state = S_IDLE;
                end
                default:     n_state = S_PREP;
            endcase
        end
    end

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.div_mode = DIV_MOD;
        unique case (r_state)
            S_PREP:  o_cmd.clear_start = 1'b1;
            S_CLEAR: o_cmd.clear_we    = 1'b1;
            S_IDLE: begin
                if (w_accept && (i_s_tuser == ACT_DRAW)) begin
                    if (i_status.exhausted) begin
                        o_cmd.load_exh = 1'b1;
                    end else begin
                        o_cmd.latch_in = 1'b1;
                    end
                end
            end
            S_MOD_START: o_cmd.div_start = 1'b1;
            S_MOD:       o_cmd.div_mode  = DIV_MOD;
            S_READ:      o_cmd.rd_en     = 1'b1;
            S_SWAP_POS:  o_cmd.wr_pos    = 1'b1;
            S_SWAP_J: begin
                o_cmd.wr_j      = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_mode  = DIV_SIDE;
            end
            S_DIV: begin
                o_cmd.div_mode    = DIV_SIDE;
                o_cmd.load_result = i_status.div_done;
            end
            S_EMIT:  o_cmd.out_load = i_status.out_free;
            default: o_cmd.div_mode = DIV_MOD;
        endcase
    end

endmodule

>>> sv/rcs_datapath.sv
// Registers, cell table memory, shared divider and output register of the sampler.
module rcs_datapath
    import rcs_pkg::*;
#(
    parameter int MAX_SIDE = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [RND_W-1:0]      i_rnd,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [ROWCOL_W-1:0]   o_row,
    output logic [ROWCOL_W-1:0]   o_column,
    output logic                  o_last,
    output logic                  o_exhausted
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int POS_W  = IDX_W + 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int SEXT_W = (SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W;
    localparam int CMP_W  = (POS_W > COUNT_CFG_W) ? POS_W : COUNT_CFG_W;
    localparam int STEP_W = $clog2(RND_W + 1);

    // Configuration
    logic [SIDE_CFG_W-1:0]  r_matrix_side;
    logic [COUNT_CFG_W-1:0] r_sample_count;
    logic                   w_cfg_hit;

    assign w_cfg_hit = i_cfg_we &&
        ((i_cfg_index == CFG_MATRIX_SIDE) || (i_cfg_index == CFG_SAMPLE_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_side  <= SIDE_RESET;
            r_sample_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MATRIX_SIDE) begin
                r_matrix_side <= i_cfg_data[SIDE_CFG_W-1:0];
            end
            if (i_cfg_index == CFG_SAMPLE_COUNT) begin
                r_sample_count <= i_cfg_data[COUNT_CFG_W-1:0];
            end
        end
    end

    // Effective side, cell total and saturated count
    logic [SEXT_W-1:0]   w_side_ext;
    logic [SIDE_W-1:0]   w_eff_side;
    logic [2*SIDE_W-1:0] w_side_sq;
    logic [POS_W-1:0]    r_total;
    logic [POS_W-1:0]    r_count;
    logic [POS_W-1:0]    n_count;

    always_comb begin
        w_side_ext = SEXT_W'(r_matrix_side);
        if (w_side_ext == '0) begin
            w_eff_side = SIDE_W'(1);
        end else if (w_side_ext > SEXT_W'(MAX_SIDE)) begin
            w_eff_side = SIDE_W'(MAX_SIDE);
        end else begin
            w_eff_side = w_side_ext[SIDE_W-1:0];
        end
        w_side_sq = w_eff_side * w_eff_side;
        if (CMP_W'(r_sample_count) > CMP_W'(r_total)) begin
            n_count = r_total;
        end else begin
            n_count = POS_W'(r_sample_count);
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= w_side_sq[POS_W-1:0];
        r_count <= n_count;
    end

    // Draw position and clearing address
    logic [POS_W-1:0] r_pos;
    logic [IDX_W-1:0] r_clr_addr;
    logic [POS_W-1:0] w_total_m1;

    assign w_total_m1 = r_total - POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear_start) begin
                r_pos      <= '0;
                r_clr_addr <= '0;
            end else if (i_cmd.clear_we) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cmd.load_result) begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    // Input capture
    logic [RND_W-1:0] r_rnd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_rnd <= i_rnd;
        end
    end

    // Shared divider
    logic [RND_W-1:0]  w_dividend;
    logic [POS_W-1:0]  w_divisor;
    logic [STEP_W-1:0] w_steps;
    logic              w_div_done;
    logic [RND_W-1:0]  w_quot;
    logic [POS_W-1:0]  w_rem;

    logic [IDX_W-1:0]  r_rd_pos;
    logic [IDX_W-1:0]  r_rd_j;

    always_comb begin
        unique case (i_cmd.div_mode)
            DIV_MOD: begin
                w_dividend = r_rnd;
                w_divisor  = r_total - r_pos;
                w_steps    = STEP_W'(RND_W);
            end
            DIV_SIDE: begin
                // Place the index in the top bits so only its bits are stepped
                w_dividend = {r_rd_j, {(RND_W-IDX_W){1'b0}}};
                w_divisor  = POS_W'(w_eff_side);
                w_steps    = STEP_W'(IDX_W);
            end
            default: begin
                w_dividend = r_rnd;
                w_divisor  = r_total - r_pos;
                w_steps    = STEP_W'(RND_W);
            end
        endcase
    end

    rcs_divider #(
        .DIVIDEND_W (RND_W),
        .DIVISOR_W  (POS_W)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .i_steps     (w_steps),
        .o_done      (w_div_done),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    // Cell table
    logic [IDX_W-1:0] mem_cells [DEPTH];
    logic [POS_W-1:0] w_j_full;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] w_pos_addr;

    assign w_j_full   = r_pos + w_rem;
    assign w_pos_addr = r_pos[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_we) begin
            mem_cells[r_clr_addr] <= r_clr_addr;
        end else if (i_cmd.wr_pos) begin
            mem_cells[w_pos_addr] <= r_rd_j;
        end else if (i_cmd.wr_j) begin
            mem_cells[r_j] <= r_rd_pos;
        end
        if (i_cmd.rd_en) begin
            r_rd_pos <= mem_cells[w_pos_addr];
            r_rd_j   <= mem_cells[w_j_full[IDX_W-1:0]];
            r_j      <= w_j_full[IDX_W-1:0];
        end
    end

    // Result staging
    logic [ROWCOL_W-1:0]       r_res_row;
    logic [ROWCOL_W-1:0]       r_res_col;
    logic                      r_res_last;
    logic                      r_res_exh;
    logic [ROWCOL_W+POS_W-1:0] w_rem_ext;

    assign w_rem_ext = {{ROWCOL_W{1'b0}}, w_rem};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_exh) begin
            r_res_row  <= '0;
            r_res_col  <= '0;
            r_res_last <= 1'b0;
            r_res_exh  <= 1'b1;
        end else if (i_cmd.load_result) begin
            r_res_row  <= w_quot[ROWCOL_W-1:0];
            r_res_col  <= w_rem_ext[ROWCOL_W-1:0];
            r_res_last <= ((r_pos + POS_W'(1)) == r_count);
            r_res_exh  <= 1'b0;
        end
    end

    // Output register
    logic                r_out_valid;
    logic [ROWCOL_W-1:0] r_out_row;
    logic [ROWCOL_W-1:0] r_out_col;
    logic                r_out_last;
    logic                r_out_exh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row  <= r_res_row;
            r_out_col  <= r_res_col;
            r_out_last <= r_res_last;
            r_out_exh  <= r_res_exh;
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_row       = r_out_row;
    assign o_column    = r_out_col;
    assign o_last      = r_out_last;
    assign o_exhausted = r_out_exh;

    always_comb begin
        o_status.clear_done  = (r_clr_addr == w_total_m1[IDX_W-1:0]);
        o_status.exhausted   = (r_pos >= r_count);
        o_status.div_done    = w_div_done;
        o_status.out_free    = !r_out_valid || i_m_tready;
        o_status.cfg_restart = w_cfg_hit;
    end

endmodule

>>> sv/random_cell_sampler_core.sv
// Top level of the random cell sampler: draws distinct matrix cells by partial shuffle.
//
// Input stream (s side): each transfer carries a random word in tdata and an action
// in tuser. Action draw picks one cell; action restart returns the table to
// identity and the draw position to zero and produces no result.
// Output stream (m side): one transfer per draw with row and column in tdata,
// tlast on the final draw of the run and tuser set once no draws remain
// (row and column zero then).
// Configuration: i_cfg_we writes matrix_side (index 0) or sample_count (index 1);
// either write restarts the run. Other indices are ignored.
// Draw steps: the shared shift-subtract divider runs once for the modulo that picks
// the swap partner, the two table cells are read and swapped, and the divider runs
// once more for the split into row and column; the result is then staged and loaded
// into the output register. An exhausted draw skips the divider. One draw is in
// flight at a time: tready returns once the result is loaded into the output
// register.
// Reset, restart and configuration writes start a clearing pass that writes
// side*side table entries, one per cycle, with tready low. A stalled receiver holds
// the result in the output register; the next item is still accepted and its result
// waits until the register frees.
module random_cell_sampler_core
    import rcs_pkg::*;
#(
    parameter int MAX_SIDE = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // s side
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [30:0] random_word, [31] zero fill
    input  logic                   i_s_tuser,   // [0] action
    // m side
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [7:0] row, [15:8] column
    output logic                   o_m_tlast,   // last draw of the run
    output logic                   o_m_tuser,   // [0] exhausted
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd                w_cmd;
    t_status             w_status;
    logic [ROWCOL_W-1:0] w_row;
    logic [ROWCOL_W-1:0] w_column;

    rcs_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rcs_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_rnd       (i_s_tdata[RND_W-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_row       (w_row),
        .o_column    (w_column),
        .o_last      (o_m_tlast),
        .o_exhausted (o_m_tuser)
    );

    // Pack row in the low byte, column above it
    assign o_m_tdata = {w_column, w_row};

    // The table has one write port: never two writes in a cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clear_we, w_cmd.wr_pos, w_cmd.wr_j}))
        else $error("cell table written twice in one cycle");

    // A cell is only produced while draws remain
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_result |-> !w_status.exhausted)
        else $error("draw completed past the sample count");

    // A restart transfer blocks input for the clearing pass
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == ACT_RESTART)) |=> !o_s_tready)
        else $error("input taken right after restart");

    // A register write restarts the run and stops input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.cfg_restart |=> !o_s_tready)
        else $error("input taken right after configuration write");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the random cell sampler core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcs_pkg::*;

    // Must match the core's default MAX_SIDE; the instance keeps the default.
    localparam int TB_MAX_SIDE = 256;
    // Upper bound on the wait from accept to output valid of a draw, rounded up.
    localparam int DRAW_LATENCY = 64;
    // A full-size clearing pass plus one draw fits well inside this.
    localparam int DRAIN_LIMIT = 70000;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_XFERS = 1426;
    localparam int NUM_PHASES = 12;
    localparam int WIDE_PHASE = 6;
    localparam int WIDE_ITEMS = 50;
    localparam int QUIET_PHASE = 1;
    localparam int DRAIN_PHASE = 3;
    localparam int REPORT_CAP = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;
    localparam logic [RND_W-1:0] RND_MAX = '1;

    typedef struct packed {
        logic [ROWCOL_W-1:0] row;
        logic [ROWCOL_W-1:0] col;
        logic                last;
        logic                exh;
    } cell_res_t;

    typedef enum logic {
        STEP_XFER,
        STEP_REG
    } step_kind_t;

    typedef struct {
        step_kind_t             kind;
        logic                   act;
        logic [RND_W-1:0]       rnd;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        bit                     typed;
        cell_res_t              want;
    } script_row_t;

    typedef enum logic [1:0] {
        BAND_TINY,
        BAND_MID,
        BAND_WIDE
    } side_band_t;

    // DUT signals; the inputs are driven to known values from time zero
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;   // [30:0] random_word, [31] zero fill
    logic                   i_s_tuser = 1'b0; // [0] action
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] o_m_tdata;        // [7:0] row, [15:8] column
    logic                   o_m_tlast;
    logic                   o_m_tuser;        // [0] exhausted
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    random_cell_sampler_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shuffle predictor: own copy of the cell table, draw position and
    // the two registers.
    // ------------------------------------------------------------------
    logic [15:0]            cell_map [TB_MAX_SIDE*TB_MAX_SIDE];
    int unsigned            draw_pos;
    logic [SIDE_CFG_W-1:0]  side_reg;
    logic [COUNT_CFG_W-1:0] count_reg;
    // Length of a clearing pass that may still be running in the core;
    // zero once a draw transfer proves the core has come back.
    int unsigned            clear_len;

    cell_res_t   cells_due[$];   // predicted draw results, oldest first
    int          mismatch_cnt = 0;
    int          results_seen = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_stalls_on = 1'b1;
    script_row_t script[$];

    // Side 0 behaves as 1; anything above the table size is clipped.
    function automatic int unsigned side_of(input logic [SIDE_CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > TB_MAX_SIDE) return TB_MAX_SIDE;
        return v;
    endfunction

    function automatic int unsigned live_total();
        int unsigned s;
        s = side_of(side_reg);
        return s * s;
    endfunction

    // Requested count, saturated to the number of cells.
    function automatic int unsigned live_count();
        int unsigned total;
        total = live_total();
        return (count_reg > total) ? total : count_reg;
    endfunction

    // Restart: identity table over the live cells, position back to zero.
    // Entries past the live cell total are never touched before the next
    // restart, so they are left alone.
    task automatic rebuild_identity();
        int unsigned total;
        total = live_total();
        for (int unsigned k = 0; k < total; k++) cell_map[k] = 16'(k);
        draw_pos = 0;
        clear_len = total;
    endtask

    task automatic shuffle_draw(input logic [RND_W-1:0] rnd, output cell_res_t res);
        int unsigned s, total, cnt, j, idx;
        logic [15:0] held;
        s = side_of(side_reg);
        total = s * s;
        cnt = live_count();
        res = '0;
        if (draw_pos >= cnt) begin
            res.exh = 1'b1;          // nothing left: coordinates stay zero
        end else begin
            // partner lies in the not-yet-drawn tail [pos, total)
            j = draw_pos + rnd % (total - draw_pos);
            held = cell_map[draw_pos];
            cell_map[draw_pos] = cell_map[j];
            cell_map[j] = held;
            idx = cell_map[draw_pos];
            res.row = ROWCOL_W'(idx / s);
            res.col = ROWCOL_W'(idx % s);
            res.last = (draw_pos + 1 == cnt);
            draw_pos++;
        end
    endtask

    function automatic cell_res_t make_cell(input int r, input int c, input bit l,
                                            input bit e);
        cell_res_t v;
        v.row = ROWCOL_W'(r);
        v.col = ROWCOL_W'(c);
        v.last = l;
        v.exh = e;
        return v;
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatch_cnt < REPORT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Drop tvalid and wait until every predicted result has come out.
    task automatic hold_sender();
        int n;
        @(negedge i_clk) i_s_tvalid <= 1'b0;
        n = 0;
        while (cells_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    // Register write, only with the core idle: drained, past the draw
    // latency and past any clearing pass a restart may have started.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        hold_sender();
        repeat (DRAW_LATENCY + clear_len) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        // Either real register restarts the run; other indices do nothing.
        if (idx == CFG_MATRIX_SIDE) begin
            side_reg = val[SIDE_CFG_W-1:0];
            rebuild_identity();
        end else if (idx == CFG_SAMPLE_COUNT) begin
            count_reg = val;
            rebuild_identity();
        end
    endtask

    // One transfer on the input stream. tvalid stays high after the accept
    // so that a zero gap gives back-to-back transfers.
    task automatic send_xfer(input logic act, input logic [RND_W-1:0] rnd,
                             input bit typed, input cell_res_t want);
        int gap;
        cell_res_t got;
        gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {1'b0, rnd};
        i_s_tuser <= act;
        do @(posedge i_clk); while (!o_s_tready);
        if (act == ACT_RESTART) begin
            rebuild_identity();
        end else begin
            shuffle_draw(rnd, got);
            clear_len = 0;
            cells_due.push_back(typed ? want : got);
        end
    endtask

    function automatic logic [RND_W-1:0] pick_word(input int unsigned total);
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) return RND_MAX;
        if (sel < 3) return RND_W'($urandom_range(0, total));
        return RND_W'($urandom);
    endfunction

    task automatic script_xfer(input logic act, input logic [RND_W-1:0] rnd);
        script_row_t r;
        r.kind = STEP_XFER;
        r.act = act;
        r.rnd = rnd;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.typed = 1'b0;
        r.want = '0;
        script.push_back(r);
    endtask

    task automatic script_want(input logic act, input logic [RND_W-1:0] rnd,
                               input cell_res_t want);
        script_row_t r;
        r.kind = STEP_XFER;
        r.act = act;
        r.rnd = rnd;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.typed = 1'b1;
        r.want = want;
        script.push_back(r);
    endtask

    task automatic script_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
        script_row_t r;
        r.kind = STEP_REG;
        r.act = ACT_DRAW;
        r.rnd = '0;
        r.reg_idx = idx;
        r.reg_val = val;
        r.typed = 1'b0;
        r.want = '0;
        script.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall per result once it shows up.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        forever begin
            stall = rx_stalls_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                @(negedge i_clk) i_m_tready <= 1'b0;
                do @(posedge i_clk); while (!o_m_tvalid);
                repeat (stall - 1) @(posedge i_clk);
            end
            @(negedge i_clk) i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    // Compare every output transfer with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        cell_res_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (cells_due.size() == 0) begin
                note_mismatch($sformatf("result %0d with no draw pending", results_seen));
            end else begin
                want = cells_due.pop_front();
                if (o_m_tdata[7:0] !== want.row)
                    note_mismatch($sformatf("result %0d row %0d, want %0d",
                                            results_seen, o_m_tdata[7:0], want.row));
                if (o_m_tdata[15:8] !== want.col)
                    note_mismatch($sformatf("result %0d column %0d, want %0d",
                                            results_seen, o_m_tdata[15:8], want.col));
                if (o_m_tlast !== want.last)
                    note_mismatch($sformatf("result %0d last %b, want %b",
                                            results_seen, o_m_tlast, want.last));
                if (o_m_tuser !== want.exh)
                    note_mismatch($sformatf("result %0d exhausted %b, want %b",
                                            results_seen, o_m_tuser, want.exh));
            end
        end
    end

    // Hard stop in case the core hangs.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          per_phase;
        int          n_items;
        int unsigned side_pick;
        int unsigned total_new;
        int unsigned count_pick;
        int unsigned sel;
        int unsigned pct;
        bit          spent;
        logic        act;
        side_band_t  band;
        logic [CFG_DATA_W-1:0] side_val;
        cell_res_t   left;

        side_reg = SIDE_RESET;
        count_reg = COUNT_RESET;
        rebuild_identity();

        // Directed part. Reset state is a 100x100 matrix with 2000 draws.
        script_want(ACT_DRAW, 0, make_cell(0, 0, 0, 0));     // zero word keeps cell 0
        script_want(ACT_DRAW, 0, make_cell(0, 1, 0, 0));     // then cell 1 in place
        script_xfer(ACT_DRAW, RND_MAX);
        script_xfer(ACT_RESTART, RND_MAX);                   // no result, identity again
        script_want(ACT_DRAW, 9999, make_cell(99, 99, 0, 0)); // pick the far corner
        // 1x1 matrix: the count saturates to a single cell
        script_reg(CFG_MATRIX_SIDE, 1);
        script_want(ACT_DRAW, 31'h2AAAAAAA, make_cell(0, 0, 1, 0));
        script_want(ACT_DRAW, 31'h55555555, make_cell(0, 0, 0, 1));
        script_want(ACT_DRAW, RND_MAX, make_cell(0, 0, 0, 1));
        // side zero acts as one, zero count is exhausted from the start
        script_reg(CFG_MATRIX_SIDE, 0);
        script_reg(CFG_SAMPLE_COUNT, 0);
        script_want(ACT_DRAW, 0, make_cell(0, 0, 0, 1));
        script_reg(CFG_IDX_LAST, '1);                        // unknown index: no effect
        script_want(ACT_DRAW, 1, make_cell(0, 0, 0, 1));
        script_reg(CFG_SAMPLE_COUNT, 17'h10000);
        script_want(ACT_DRAW, RND_MAX, make_cell(0, 0, 1, 0));
        // 3x3, count saturates to 9: run all the way through
        script_reg(CFG_MATRIX_SIDE, 3);
        script_xfer(ACT_DRAW, 0);
        script_xfer(ACT_DRAW, RND_MAX);
        script_xfer(ACT_DRAW, 31'h40000000);
        script_xfer(ACT_DRAW, 31'h12345678);
        script_xfer(ACT_DRAW, 5);
        script_xfer(ACT_DRAW, 31'h7FFFFFFE);
        script_xfer(ACT_DRAW, 31'h0F0F0F0F);
        script_xfer(ACT_DRAW, 7);
        script_xfer(ACT_DRAW, 31'h3C3C3C3C);
        script_want(ACT_DRAW, 3, make_cell(0, 0, 0, 1));
        script_xfer(ACT_RESTART, 0);
        script_want(ACT_DRAW, 8, make_cell(2, 2, 0, 0));
        // side above the table size clips to 256; count saturates to 65536
        script_reg(CFG_MATRIX_SIDE, '1);
        script_reg(CFG_SAMPLE_COUNT, '1);
        script_want(ACT_DRAW, 65535, make_cell(255, 255, 0, 0));
        script_xfer(ACT_DRAW, RND_MAX);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == STEP_REG)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                send_xfer(script[i].act, script[i].rnd, script[i].typed, script[i].want);
        end

        // Random part: one register setting per phase, mostly small
        // matrices so runs reach their end and restarts stay cheap.
        per_phase = (RANDOM_XFERS - WIDE_ITEMS) / (NUM_PHASES - 1);
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == WIDE_PHASE)
                band = BAND_WIDE;
            else if (p == 2 || p == 9)
                band = BAND_MID;
            else
                band = BAND_TINY;

            // one phase runs flat out on both sides
            tx_gaps_on = (p != QUIET_PHASE) && ($urandom_range(0, 3) != 0);
            rx_stalls_on = (p != QUIET_PHASE) && ($urandom_range(0, 3) != 0);

            case (band)
                BAND_WIDE: side_pick = $urandom_range(150, 511);
                BAND_MID:  side_pick = $urandom_range(17, 64);
                default:   side_pick = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
            endcase
            total_new = side_of(SIDE_CFG_W'(side_pick)) * side_of(SIDE_CFG_W'(side_pick));

            // zero, saturating or in-range count
            sel = $urandom_range(0, 9);
            if (band == BAND_WIDE)
                count_pick = $urandom_range(20, 60);
            else if (sel == 0)
                count_pick = 0;
            else if (sel < 3)
                count_pick = $urandom_range(total_new, 17'h1FFFF);
            else
                count_pick = $urandom_range(1, total_new);

            // upper data bits are random; the core keeps only the low nine
            side_val = CFG_DATA_W'($urandom & 32'h1FE00) | CFG_DATA_W'(side_pick);
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_MATRIX_SIDE, side_val);
                write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'(count_pick));
            end else begin
                write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'(count_pick));
                write_reg(CFG_MATRIX_SIDE, side_val);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_SAMPLE_COUNT + 1, CFG_IDX_LAST)),
                          CFG_DATA_W'($urandom));

            n_items = (band == BAND_WIDE) ? WIDE_ITEMS : per_phase;
            for (int i = 0; i < n_items; i++) begin
                // let the pipeline run dry once in the middle of a phase
                if (p == DRAIN_PHASE && i == n_items / 2) hold_sender();

                // restart mostly once the run is used up; a restart on a
                // wide matrix costs a full clearing pass, so keep it rare
                spent = (draw_pos >= live_count());
                if (spent)
                    pct = (band == BAND_WIDE) ? 25 : (band == BAND_MID) ? 50 : 70;
                else
                    pct = (band == BAND_WIDE) ? 0 : (band == BAND_MID) ? 1 : 3;
                act = ($urandom_range(0, 99) < pct) ? ACT_RESTART : ACT_DRAW;
                send_xfer(act, pick_word(live_total()), 1'b0, '0);
            end
        end

        // Drain, give stray results a chance to show, then judge.
        hold_sender();
        repeat (DRAW_LATENCY) @(posedge i_clk);
        while (cells_due.size() != 0) begin
            left = cells_due.pop_front();
            note_mismatch($sformatf("predicted result never came out (row %0d column %0d)",
                                    left.row, left.col));
        end

        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/rcs_pkg.sv
sv/rcs_divider.sv
sv/rcs_controller.sv
sv/rcs_datapath.sv
sv/random_cell_sampler_core.sv
tb/tb.sv
